@@ sv/aip_pkg.sv @@
package aip_pkg;

  // fixed field widths
  localparam int CHAR_W   = 8;
  localparam int BASE_W   = 6;
  localparam int RESULT_W = 64;
  localparam int OFFSET_W = 12;

  // configuration register indexes
  localparam logic CFG_NUMBER_BASE = 1'b0;
  localparam logic CFG_SIGNED_MODE = 1'b1;

  // radix values
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  // digit code for a character that is no digit at all
  localparam logic [BASE_W-1:0] NOT_DIGIT = 6'd63;

  // character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0b;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0c;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              first_char;
  } char_word_t;

  typedef struct packed {
    logic [RESULT_W-1:0] parsed_value;
    logic [OFFSET_W-1:0] end_offset;
    logic                no_digits;
    logic                range_error;
  } result_word_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

  // digit value 0..35, NOT_DIGIT otherwise
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      v = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      v = c - CH_UP_A + 8'd10;
    end else begin
      v = 8'(NOT_DIGIT);
    end
    return v[BASE_W-1:0];
  endfunction

endpackage

@@ sv/ascii_integer_parser.sv @@
// ascii_integer_parser: streaming ascii to integer conversion, one character per word
//
// char channel (char_valid / char_stall / char_word) carries one character a word;
// first_char set marks the start of a new string and drops any unfinished parse.
// leading whitespace, one optional sign, an optional 0x prefix and then digits are
// consumed; the first non-digit ends the parse and yields one result word on the
// result channel (result_valid / result_stall / result_word). characters after that
// are ignored until the next first_char.
// cfg port: cfg_we with cfg_index selects number_base (0) or signed_mode (1);
// write only while the block is idle.
// throughput: one character per cycle while char_stall is low; each character
// goes through a single 64 x 6 multiply-add into the state registers in the cycle
// it is taken. the result word of a terminating character is registered.
// the result register is backed by a one-word skid register; char_stall is high only
// while the skid register is full, so characters keep flowing while one result waits.
// reset (rst, synchronous) clears the parse state, the valid flags of both result
// registers and the configuration (auto base, unsigned).
module ascii_integer_parser #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_OFFSET  = 4095
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        char_valid,
  output logic                        char_stall,
  input  aip_pkg::char_word_t         char_word,
  output logic                        result_valid,
  input  logic                        result_stall,
  output aip_pkg::result_word_t       result_word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [aip_pkg::BASE_W-1:0]  cfg_data
);

  localparam int POS_W  = $clog2(MAX_OFFSET + 1);
  localparam int PROD_W = VALUE_WIDTH + aip_pkg::BASE_W + 1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_START,
    PH_ZERO,
    PH_AFTERX,
    PH_DIGITS
  } phase_t;

  // configuration
  logic [aip_pkg::BASE_W-1:0] number_base;
  logic                       signed_mode;

  // parse state
  phase_t                     parse_phase;
  logic [aip_pkg::BASE_W-1:0] active_base;
  logic [VALUE_WIDTH-1:0]     accumulator;
  logic                       overflow_seen;
  logic                       negative_sign;
  logic [POS_W-1:0]           char_position;
  logic                       digit_seen;

  phase_t                     parse_phase_next;
  logic [aip_pkg::BASE_W-1:0] active_base_next;
  logic [VALUE_WIDTH-1:0]     accumulator_next;
  logic                       overflow_seen_next;
  logic                       negative_sign_next;
  logic [POS_W-1:0]           char_position_next;
  logic                       digit_seen_next;

  // result registers
  aip_pkg::result_word_t      skid_word;
  logic                       skid_valid;

  logic                       char_fire;
  logic                       result_fire;
  logic                       emit;
  aip_pkg::result_word_t      emit_word;

  // per-character scratch
  logic [aip_pkg::CHAR_W-1:0] c;
  logic [aip_pkg::BASE_W-1:0] d;
  logic                       done;
  logic                       advance;
  logic [POS_W-1:0]           end_pos;
  logic [PROD_W-1:0]          prod;
  logic [VALUE_WIDTH-1:0]     half;
  logic [VALUE_WIDTH-1:0]     val;
  logic                       range;

  assign char_stall  = skid_valid;
  assign char_fire   = char_valid && !char_stall;
  assign result_fire = result_valid && !result_stall;

  // one character step, in the order of the parse phases
  always_comb begin
    c    = char_word.char_code;
    d    = aip_pkg::digit_of(c);
    done = 1'b0;
    advance = 1'b0;
    emit = 1'b0;
    end_pos = char_position;
    prod = '0;

    if (char_word.first_char) begin
      parse_phase_next   = PH_LEAD;
      active_base_next   = '0;
      accumulator_next   = '0;
      overflow_seen_next = 1'b0;
      negative_sign_next = 1'b0;
      char_position_next = '0;
      digit_seen_next    = 1'b0;
    end else begin
      parse_phase_next   = parse_phase;
      active_base_next   = active_base;
      accumulator_next   = accumulator;
      overflow_seen_next = overflow_seen;
      negative_sign_next = negative_sign;
      char_position_next = char_position;
      digit_seen_next    = digit_seen;
    end
    end_pos = char_position_next;

    if (parse_phase_next == PH_IDLE) begin
      done = 1'b1;
    end

    // whitespace and sign
    if (!done && parse_phase_next == PH_LEAD) begin
      if (aip_pkg::is_blank(c)) begin
        advance = 1'b1;
        done    = 1'b1;
      end else begin
        parse_phase_next = PH_START;
        if (c == aip_pkg::CH_MINUS || c == aip_pkg::CH_PLUS) begin
          negative_sign_next = (c == aip_pkg::CH_MINUS);
          advance = 1'b1;
          done    = 1'b1;
        end
      end
    end

    // base selection and prefix
    if (!done && parse_phase_next == PH_START) begin
      if (number_base == aip_pkg::BASE_AUTO) begin
        if (c == aip_pkg::CH_ZERO) begin
          active_base_next = aip_pkg::BASE_OCT;
          digit_seen_next  = 1'b1;
          parse_phase_next = PH_ZERO;
          advance = 1'b1;
          done    = 1'b1;
        end else begin
          active_base_next = aip_pkg::BASE_DEC;
        end
      end else begin
        active_base_next = (number_base > aip_pkg::BASE_MAX) ? aip_pkg::BASE_MAX
                                                             : number_base;
        if (active_base_next == aip_pkg::BASE_HEX && c == aip_pkg::CH_ZERO) begin
          digit_seen_next  = 1'b1;
          parse_phase_next = PH_ZERO;
          advance = 1'b1;
          done    = 1'b1;
        end
      end
      if (!done) begin
        parse_phase_next = PH_DIGITS;
      end
    end else if (!done && parse_phase_next == PH_ZERO) begin
      if (c == aip_pkg::CH_LO_X || c == aip_pkg::CH_UP_X) begin
        active_base_next = aip_pkg::BASE_HEX;
        parse_phase_next = PH_AFTERX;
        advance = 1'b1;
        done    = 1'b1;
      end else begin
        parse_phase_next = PH_DIGITS;
      end
    end else if (!done && parse_phase_next == PH_AFTERX) begin
      if (d < active_base_next) begin
        parse_phase_next = PH_DIGITS;
      end else begin
        // "0x" with no hex digit: the value is the lone zero, offset just after it
        accumulator_next = '0;
        emit    = 1'b1;
        end_pos = (char_position_next != '0) ? char_position_next - 1'b1 : '0;
        done    = 1'b1;
      end
    end

    // digit accumulation
    if (!done) begin
      if (d < active_base_next) begin
        prod = PROD_W'(accumulator_next) * PROD_W'(active_base_next) + PROD_W'(d);
        if (|prod[PROD_W-1:VALUE_WIDTH]) begin
          overflow_seen_next = 1'b1;
        end
        accumulator_next = prod[VALUE_WIDTH-1:0];
        digit_seen_next  = 1'b1;
        advance = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    if (advance && char_position_next < POS_W'(MAX_OFFSET)) begin
      char_position_next = char_position_next + 1'b1;
    end
    if (emit) begin
      parse_phase_next = PH_IDLE;
    end
  end

  // final value: wrap, saturate or clamp
  always_comb begin
    half  = '0;
    half[VALUE_WIDTH-1] = 1'b1;
    val   = '0;
    range = 1'b0;
    if (signed_mode) begin
      if (negative_sign_next) begin
        if (overflow_seen_next || accumulator_next > half) begin
          val   = half;
          range = 1'b1;
        end else begin
          val = '0 - accumulator_next;
        end
      end else begin
        if (overflow_seen_next || accumulator_next > half - 1'b1) begin
          val   = half - 1'b1;
          range = 1'b1;
        end else begin
          val = accumulator_next;
        end
      end
    end else begin
      if (overflow_seen_next) begin
        val   = '1;
        range = 1'b1;
      end else begin
        val = negative_sign_next ? '0 - accumulator_next : accumulator_next;
      end
    end

    if (digit_seen_next) begin
      emit_word.parsed_value = aip_pkg::RESULT_W'(val);
      emit_word.end_offset   = aip_pkg::OFFSET_W'(end_pos);
      emit_word.no_digits    = 1'b0;
      emit_word.range_error  = range;
    end else begin
      emit_word.parsed_value = '0;
      emit_word.end_offset   = '0;
      emit_word.no_digits    = 1'b1;
      emit_word.range_error  = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= aip_pkg::BASE_AUTO;
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        aip_pkg::CFG_NUMBER_BASE: number_base <= cfg_data;
        aip_pkg::CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_IDLE;
      active_base   <= '0;
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      negative_sign <= 1'b0;
      char_position <= '0;
      digit_seen    <= 1'b0;
    end else if (char_fire) begin
      parse_phase   <= parse_phase_next;
      active_base   <= active_base_next;
      accumulator   <= accumulator_next;
      overflow_seen <= overflow_seen_next;
      negative_sign <= negative_sign_next;
      char_position <= char_position_next;
      digit_seen    <= digit_seen_next;
    end
  end

  // result register with skid: the skid word always drains first
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_fire) begin
      result_valid <= skid_valid || (char_fire && emit);
      skid_valid   <= 1'b0;
    end else if (char_fire && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_fire) begin
      result_word <= skid_valid ? skid_word : emit_word;
    end else if (char_fire && emit) begin
      skid_word <= emit_word;
    end
  end

  // a full skid word means the result register is full too
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> result_valid)
    else $error("skid word held with empty result register");

  // stall only comes up after a result word was held back
  assert property (@(posedge clk) disable iff (rst)
    $rose(char_stall) |-> $past(result_valid && result_stall))
    else $error("char_stall raised without a stalled result");

  // an empty parse gives zero value, zero offset and no range flag
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.no_digits) |->
      (result_word.parsed_value == '0 && result_word.end_offset == '0 &&
       !result_word.range_error))
    else $error("no-digit result with nonzero payload");

  // idle phase does not move the parse state
  assert property (@(posedge clk) disable iff (rst)
    (char_fire && parse_phase == PH_IDLE && !char_word.first_char) |=>
      (parse_phase == PH_IDLE && $stable(char_position)))
    else $error("idle parse state changed without first_char");

endmodule

@@ tb/ascii_integer_parser_checker.sv @@
`timescale 1ns / 1ps
module ascii_integer_parser_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  input  logic                       char_stall,
  input  aip_pkg::char_word_t        char_word,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  aip_pkg::result_word_t      result_word,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [aip_pkg::BASE_W-1:0] cfg_data,
  output int                         mismatch_count,
  output int                         words_outstanding
);

  localparam logic [aip_pkg::OFFSET_W-1:0] OFFSET_LIMIT = 12'd4095;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_START, PH_ZERO, PH_AFTERX, PH_DIGITS
  } parse_phase_t;

  parse_phase_t                 phase;
  logic [aip_pkg::BASE_W-1:0]   radix;
  logic [aip_pkg::RESULT_W-1:0] acc;
  logic                         ovf;
  logic                         neg;
  logic                         digit_seen;
  logic [aip_pkg::OFFSET_W-1:0] pos;
  logic [aip_pkg::BASE_W-1:0]   base_reg;
  logic                         signed_reg;
  aip_pkg::result_word_t        parsed_q[$];
  int                           fails = 0;

  assign mismatch_count = fails;

  function automatic logic blank_char(input logic [aip_pkg::CHAR_W-1:0] c);
    return c == aip_pkg::CH_SPACE || c == aip_pkg::CH_TAB || c == aip_pkg::CH_LF ||
           c == aip_pkg::CH_CR || c == aip_pkg::CH_FF || c == aip_pkg::CH_VT;
  endfunction

  // 0..35 for digit characters, 99 for anything else
  function automatic int digit_value(input logic [aip_pkg::CHAR_W-1:0] c);
    if (c >= aip_pkg::CH_ZERO && c <= aip_pkg::CH_NINE) return int'(c - aip_pkg::CH_ZERO);
    if (c >= aip_pkg::CH_LO_A && c <= aip_pkg::CH_LO_Z)
      return int'(c - aip_pkg::CH_LO_A) + 10;
    if (c >= aip_pkg::CH_UP_A && c <= aip_pkg::CH_UP_Z)
      return int'(c - aip_pkg::CH_UP_A) + 10;
    return 99;
  endfunction

  function automatic aip_pkg::result_word_t conclude_parse(
    input logic [aip_pkg::OFFSET_W-1:0] stop
  );
    aip_pkg::result_word_t        res;
    logic [aip_pkg::RESULT_W-1:0] half;
    res = '0;
    half = {1'b1, {(aip_pkg::RESULT_W-1){1'b0}}};
    phase = PH_IDLE;
    if (!digit_seen) begin
      res.no_digits = 1'b1;
      return res;
    end
    res.end_offset = stop;
    if (signed_reg) begin
      if (neg) begin
        if (ovf || acc > half) begin
          res.parsed_value = half;
          res.range_error = 1'b1;
        end else begin
          res.parsed_value = -acc;
        end
      end else if (ovf || acc > half - 1) begin
        res.parsed_value = half - 1;
        res.range_error = 1'b1;
      end else begin
        res.parsed_value = acc;
      end
    end else if (ovf) begin
      res.parsed_value = '1;
      res.range_error = 1'b1;
    end else begin
      res.parsed_value = neg ? -acc : acc;
    end
    return res;
  endfunction

  task automatic parse_char(input aip_pkg::char_word_t w, output logic emit,
                            output aip_pkg::result_word_t res);
    logic [aip_pkg::CHAR_W-1:0]   c;
    logic [aip_pkg::OFFSET_W-1:0] at;
    logic [aip_pkg::RESULT_W-1:0] d64;
    logic [aip_pkg::RESULT_W-1:0] r64;
    int                           d;
    logic                         moved;
    emit = 1'b0;
    res = '0;
    c = w.char_code;
    moved = 1'b0;
    if (w.first_char) begin
      phase = PH_LEAD;
      radix = '0;
      acc = '0;
      ovf = 1'b0;
      neg = 1'b0;
      pos = '0;
      digit_seen = 1'b0;
    end
    if (phase == PH_IDLE) return;
    at = pos;
    d = digit_value(c);
    if (phase == PH_LEAD) begin
      if (blank_char(c)) begin
        moved = 1'b1;
      end else begin
        phase = PH_START;
        if (c == aip_pkg::CH_PLUS || c == aip_pkg::CH_MINUS) begin
          neg = (c == aip_pkg::CH_MINUS);
          moved = 1'b1;
        end
      end
    end
    if (!moved) begin
      case (phase)
        PH_START: begin
          if (base_reg == aip_pkg::BASE_AUTO) begin
            if (c == aip_pkg::CH_ZERO) begin
              radix = aip_pkg::BASE_OCT;
              digit_seen = 1'b1;
              phase = PH_ZERO;
              moved = 1'b1;
            end else begin
              radix = aip_pkg::BASE_DEC;
            end
          end else begin
            radix = (base_reg > aip_pkg::BASE_MAX) ? aip_pkg::BASE_MAX : base_reg;
            if (radix == aip_pkg::BASE_HEX && c == aip_pkg::CH_ZERO) begin
              digit_seen = 1'b1;
              phase = PH_ZERO;
              moved = 1'b1;
            end
          end
          if (!moved) phase = PH_DIGITS;
        end
        PH_ZERO: begin
          if (c == aip_pkg::CH_LO_X || c == aip_pkg::CH_UP_X) begin
            radix = aip_pkg::BASE_HEX;
            phase = PH_AFTERX;
            moved = 1'b1;
          end else begin
            phase = PH_DIGITS;
          end
        end
        PH_AFTERX: begin
          // "0x" without a hex digit: the value is the lone zero
          if (d < int'(radix)) begin
            phase = PH_DIGITS;
          end else begin
            acc = '0;
            emit = 1'b1;
            res = conclude_parse((at > 0) ? at - 1'b1 : aip_pkg::OFFSET_W'(0));
            return;
          end
        end
        default: ;
      endcase
    end
    if (!moved) begin
      if (d < int'(radix)) begin
        d64 = aip_pkg::RESULT_W'(d);
        r64 = aip_pkg::RESULT_W'(radix);
        if (acc > ({aip_pkg::RESULT_W{1'b1}} - d64) / r64) ovf = 1'b1;
        acc = acc * r64 + d64;
        digit_seen = 1'b1;
      end else begin
        emit = 1'b1;
        res = conclude_parse(at);
        return;
      end
    end
    if (pos < OFFSET_LIMIT) pos = pos + 1'b1;
  endtask

  always @(posedge clk) begin : watch
    aip_pkg::result_word_t want;
    logic                  emit;
    if (rst) begin
      phase = PH_IDLE;
      radix = '0;
      acc = '0;
      ovf = 1'b0;
      neg = 1'b0;
      pos = '0;
      digit_seen = 1'b0;
      base_reg = aip_pkg::BASE_AUTO;
      signed_reg = 1'b0;
      parsed_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == aip_pkg::CFG_NUMBER_BASE) base_reg = cfg_data;
        else signed_reg = cfg_data[0];
      end
      // compare before predicting, a new word cannot match in its own cycle
      if (result_valid && !result_stall) begin
        if (parsed_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected no word, got value %h offset %0d none %b range %b",
                     result_word.parsed_value, result_word.end_offset,
                     result_word.no_digits, result_word.range_error);
        end else begin
          want = parsed_q.pop_front();
          if (result_word !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected value %h offset %0d none %b range %b, %s",
                       want.parsed_value, want.end_offset, want.no_digits,
                       want.range_error,
                       $sformatf("got value %h offset %0d none %b range %b",
                                 result_word.parsed_value, result_word.end_offset,
                                 result_word.no_digits, result_word.range_error));
          end
        end
      end
      if (char_valid && !char_stall) begin
        parse_char(char_word, emit, want);
        if (emit) parsed_q.push_back(want);
      end
    end
    words_outstanding <= parsed_q.size();
  end

endmodule

@@ tb/ascii_integer_parser_test.sv @@
`timescale 1ns / 1ps
module ascii_integer_parser_test;

  // generous bound on the length of a correct run
  localparam int CYCLE_LIMIT = 400000;
  // long receiver hold-off so the block fills and stalls its char input
  localparam int HOLD_CYCLES = 300;
  // char words per random phase
  localparam int PHASE_WORDS = 110;
  localparam int NUM_PHASES  = 12;

  typedef logic [aip_pkg::CHAR_W-1:0] char_q_t[$];

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       char_valid;
  logic                       char_stall;
  aip_pkg::char_word_t        char_word;
  logic                       result_valid;
  logic                       result_stall;
  aip_pkg::result_word_t      result_word;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [aip_pkg::BASE_W-1:0] cfg_data;

  int mismatch_count;
  int words_outstanding;
  int cycle_count = 0;

  // idle percentages, changed per phase by the stimulus
  int send_idle_pct = 11;
  int recv_idle_pct = 77;
  bit hold_req = 1'b0;

  // radix and sign mode of each random phase, extremes included
  logic [aip_pkg::BASE_W-1:0] phase_base [NUM_PHASES];
  logic                       phase_signed [NUM_PHASES];

  always #6 clk = ~clk;

  ascii_integer_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ascii_integer_parser_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .char_valid        (char_valid),
    .char_stall        (char_stall),
    .char_word         (char_word),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result_word       (result_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .words_outstanding (words_outstanding)
  );

  // hard stop in case the block hangs or drops a word
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // offer one char word, with a random gap first, and wait until it is taken;
  // valid stays high into the next word when no gap is drawn
  task automatic send_word(input logic [aip_pkg::CHAR_W-1:0] code, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word <= '{char_code: code, first_char: first};
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  // a string: first_char only on its opening character
  task automatic send_text(input char_q_t txt);
    foreach (txt[i]) send_word(txt[i], i == 0);
  endtask

  // register writes only while the block is idle; cfg_we drops again after each write
  task automatic write_cfg(input logic idx, input logic [aip_pkg::BASE_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, let every expected word come out, then idle with char_valid low
  task automatic drain();
    char_valid <= 1'b0;
    @(posedge clk);
    while (words_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [aip_pkg::CHAR_W-1:0] digit_char(input int value);
    if (value < 10) return aip_pkg::CH_ZERO + aip_pkg::CHAR_W'(value);
    if ($urandom_range(1)) return aip_pkg::CH_LO_A + aip_pkg::CHAR_W'(value - 10);
    return aip_pkg::CH_UP_A + aip_pkg::CHAR_W'(value - 10);
  endfunction

  // mostly well-formed number: blanks, sign, prefix and digits of a chosen value,
  // values biased toward the signed and unsigned limits and past them
  function automatic char_q_t number_text(input logic [aip_pkg::BASE_W-1:0] radix_cfg);
    char_q_t                    txt;
    char_q_t                    digs;
    logic [aip_pkg::CHAR_W-1:0] blank_set [6];
    logic [63:0]                v;
    logic [63:0]                r64;
    int                         eb;
    int                         pick;
    blank_set = '{aip_pkg::CH_SPACE, aip_pkg::CH_TAB, aip_pkg::CH_LF, aip_pkg::CH_VT,
                  aip_pkg::CH_FF, aip_pkg::CH_CR};
    repeat ($urandom_range(0, 2)) txt.push_back(blank_set[$urandom_range(5)]);
    pick = $urandom_range(99);
    if (pick < 40) txt.push_back(aip_pkg::CH_MINUS);
    else if (pick < 60) txt.push_back(aip_pkg::CH_PLUS);
    // a second sign ends the parse with no digits
    if ($urandom_range(19) == 0)
      txt.push_back($urandom_range(1) ? aip_pkg::CH_PLUS : aip_pkg::CH_MINUS);
    if (radix_cfg == aip_pkg::BASE_AUTO) begin
      pick = $urandom_range(2);
      if (pick == 0) begin
        eb = 16;
        txt.push_back(aip_pkg::CH_ZERO);
        txt.push_back($urandom_range(1) ? aip_pkg::CH_LO_X : aip_pkg::CH_UP_X);
      end else if (pick == 1) begin
        eb = 8;
        txt.push_back(aip_pkg::CH_ZERO);
      end else begin
        eb = 10;
      end
    end else begin
      eb = (radix_cfg > aip_pkg::BASE_MAX) ? int'(aip_pkg::BASE_MAX) : int'(radix_cfg);
      if (eb == 16 && $urandom_range(1)) begin
        txt.push_back(aip_pkg::CH_ZERO);
        txt.push_back($urandom_range(1) ? aip_pkg::CH_LO_X : aip_pkg::CH_UP_X);
      end
    end
    // radix one only knows the digit zero
    if (eb == 1) begin
      repeat ($urandom_range(1, 6)) txt.push_back(aip_pkg::CH_ZERO);
      return txt;
    end
    pick = $urandom_range(99);
    if (pick < 25) v = 64'($urandom_range(1000));
    else if (pick < 50) v = {$urandom, $urandom};
    else if (pick < 70) v = 64'h8000_0000_0000_0000 - 64'd3 + 64'($urandom_range(6));
    else if (pick < 80) v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
    else v = {$urandom, $urandom};
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) txt.push_back(aip_pkg::CH_ZERO);
    r64 = 64'(eb);
    do begin
      digs.push_front(digit_char(int'(v % r64)));
      v = v / r64;
    end while (v != 0);
    // extra digits push the value past 64 bits
    if (pick >= 80) repeat ($urandom_range(1, 3)) digs.push_back(digit_char($urandom_range(eb - 1)));
    foreach (digs[i]) txt.push_back(digs[i]);
    return txt;
  endfunction

  initial begin : stimulus
    char_q_t                    txt;
    logic [aip_pkg::BASE_W-1:0] cfg_word;
    int                         sent;
    int                         pick;
    int                         n;
    rst = 1'b1;
    char_valid = 1'b0;
    char_word = '0;
    cfg_we = 1'b0;
    cfg_index = aip_pkg::CFG_NUMBER_BASE;
    cfg_data = '0;
    phase_base = '{aip_pkg::BASE_AUTO, aip_pkg::BASE_AUTO, aip_pkg::BASE_DEC,
                   aip_pkg::BASE_HEX, 6'd1, 6'd2, aip_pkg::BASE_MAX, 6'd63,
                   aip_pkg::BASE_OCT, aip_pkg::BASE_HEX, aip_pkg::BASE_DEC,
                   aip_pkg::BASE_AUTO};
    phase_signed = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                     1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset configuration: auto base, unsigned
    // a char before any first_char is ignored
    send_word(aip_pkg::CH_LO_Z, 1'b0);
    // every blank kind, minus sign, hex prefix, mixed case, 0xff as terminator
    txt = '{aip_pkg::CH_SPACE, aip_pkg::CH_TAB, aip_pkg::CH_LF, aip_pkg::CH_CR,
            aip_pkg::CH_FF, aip_pkg::CH_VT, aip_pkg::CH_MINUS, aip_pkg::CH_ZERO,
            aip_pkg::CH_LO_X, aip_pkg::CH_LO_A, aip_pkg::CH_UP_A, aip_pkg::CH_NINE,
            8'hFF};
    send_text(txt);
    // trailing char after the terminator is ignored
    send_word(aip_pkg::CH_LO_Z, 1'b0);
    // lone zero: "0x" then a non-hex char
    txt = '{aip_pkg::CH_ZERO, aip_pkg::CH_UP_X, aip_pkg::CH_UP_Z};
    send_text(txt);
    // second sign stops the parse, the digit after it is ignored
    txt = '{aip_pkg::CH_PLUS, aip_pkg::CH_MINUS, aip_pkg::CH_NINE};
    send_text(txt);
    // unfinished string dropped by a new first_char, then a nul terminator
    txt = '{aip_pkg::CH_ZERO, aip_pkg::CH_ZERO};
    send_text(txt);
    txt = '{aip_pkg::CH_NINE, 8'h00};
    send_text(txt);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // sender idles rarely and receiver often, then the reverse, then no idling
      if (ph < 4) begin
        send_idle_pct = 11;
        recv_idle_pct = 77;
      end else if (ph < 8) begin
        send_idle_pct = 77;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(aip_pkg::CFG_NUMBER_BASE, phase_base[ph]);
      // upper bits of the sign mode write are don't-care, keep them random
      cfg_word = aip_pkg::BASE_W'($urandom);
      cfg_word[0] = phase_signed[ph];
      write_cfg(aip_pkg::CFG_SIGNED_MODE, cfg_word);
      if (ph == 1) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // unfinished: the next first_char cuts it off
          txt = number_text(phase_base[ph]);
          while (txt.size() > 1 && $urandom_range(1)) void'(txt.pop_back());
          send_text(txt);
          sent += txt.size();
        end else if (pick < 20) begin
          // noise: random bytes, first_char now and then
          n = $urandom_range(1, 6);
          for (int k = 0; k < n; k++)
            send_word(aip_pkg::CHAR_W'($urandom), (k == 0) || ($urandom_range(3) == 0));
          sent += n;
        end else begin
          txt = number_text(phase_base[ph]);
          case ($urandom_range(3))
            0: txt.push_back(8'h00);
            1: txt.push_back(aip_pkg::CH_SPACE);
            2: txt.push_back(aip_pkg::CHAR_W'($urandom));
            default: txt.push_back(aip_pkg::CH_MINUS);
          endcase
          send_text(txt);
          sent += txt.size();
          // ignored chars after the terminator
          if (pick >= 85)
            repeat ($urandom_range(1, 3)) send_word(aip_pkg::CHAR_W'($urandom), 1'b0);
        end
      end
      // a nul string always ends the parse, so the block is idle for the writes
      txt = '{8'h00};
      send_text(txt);
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
